[hw/rtl/svseq_pkg.sv]
// Shared types, codes and reset tables for the servo pulse sequencer.
package svseq_pkg;

    localparam int unsigned WIDTH_W    = 10;  // pulse width and limit width
    localparam int unsigned KEY_W      = 8;
    localparam int unsigned SEL_W      = 3;
    localparam int unsigned MASK_W     = 4;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned REG_COUNT  = 8;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [SEL_W-1:0] NO_SERVO = 3'd4;

    typedef enum logic [2:0] {
        ST_SELECTED = 3'd0,
        ST_ADJUSTED = 3'd1,
        ST_NO_SERVO = 3'd2,
        ST_INVALID  = 3'd3,
        ST_TICK     = 3'd4
    } t_status;

    // Result fields known at accept time, plus what the update stage must do.
    typedef struct packed {
        t_status               status;
        logic                  load;     // even tick
        logic                  rd_duty;  // even tick on a real channel slot
        logic                  adj;      // adjust the selected width
        logic                  add;      // 1 = add step, 0 = subtract step
        logic [MASK_W-1:0]     steer;
        logic [MASK_W-1:0]     clr;
        logic [SEL_W-1:0]      sel;
    } t_s0_info;

    // Pulse width after reset, per channel; channels past the fourth start at 0.
    function automatic logic [WIDTH_W-1:0] width_reset(input logic [2:0] idx);
        logic [WIDTH_W-1:0] w;
        case (idx)
            3'd0:    w = 10'd312;
            3'd1:    w = 10'd341;
            3'd2:    w = 10'd542;
            3'd3:    w = 10'd310;
            default: w = '0;
        endcase
        return w;
    endfunction

    localparam logic [WIDTH_W-1:0] MAX_RESET [4] = '{10'd592, 10'd502, 10'd602, 10'd322};
    localparam logic [WIDTH_W-1:0] MIN_RESET [4] = '{10'd142, 10'd342, 10'd292, 10'd202};

endpackage

[hw/rtl/svseq_width_mem.sv]
// Pulse width memory: registered read, per-entry valid bits, write bypass.
module svseq_width_mem #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]       i_rd_addr,
    output logic [svseq_pkg::WIDTH_W-1:0]  o_rd_data,
    input  logic                           i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]       i_wr_addr,
    input  logic [svseq_pkg::WIDTH_W-1:0]  i_wr_data
);
    import svseq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic [WIDTH_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [WIDTH_W-1:0] r_rdata;
    logic [AW-1:0]      r_rd_addr;
    logic               r_fw_vld;
    logic [AW-1:0]      r_fw_addr;
    logic [WIDTH_W-1:0] r_fw_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata   <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : width_reset(3'(i_rd_addr));
            r_rd_addr <= i_rd_addr;
        end
        if (i_wr_en) begin
            r_fw_addr <= i_wr_addr;
            r_fw_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_fw_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
            r_fw_vld         <= 1'b1;
        end
    end

    // Take the last write when it hit the entry being read; it may have landed
    // on the same edge as the read.
    assign o_rd_data = (r_fw_vld && (r_fw_addr == r_rd_addr)) ? r_fw_data : r_rdata;

endmodule

[hw/rtl/svseq_decode.sv]
// Front end: decode keys and ticks, keep selection and slot state.
module svseq_decode #(
    parameter int unsigned NUM_CHANNELS = 4,
    parameter int unsigned AW           = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_tick,
    input  logic [svseq_pkg::KEY_W-1:0] i_key,
    output svseq_pkg::t_s0_info         o_info,
    output logic [AW-1:0]               o_addr
);
    import svseq_pkg::*;

    localparam int unsigned SLOT_W = $clog2(NUM_CHANNELS + 1);

    localparam logic [KEY_W-1:0] KEY_1   = 8'h31;
    localparam logic [KEY_W-1:0] KEY_2   = 8'h32;
    localparam logic [KEY_W-1:0] KEY_3   = 8'h33;
    localparam logic [KEY_W-1:0] KEY_4   = 8'h34;
    localparam logic [KEY_W-1:0] KEY_ADD = 8'h61;
    localparam logic [KEY_W-1:0] KEY_SUB = 8'h64;

    logic [SEL_W-1:0]  r_chosen, n_chosen;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_odd, n_odd;
    logic              idle_slot;
    logic [3:0]        addr_wide;

    always_comb begin
        n_chosen  = r_chosen;
        n_slot    = r_slot;
        n_odd     = r_odd;
        idle_slot = (r_slot >= SLOT_W'(NUM_CHANNELS));
        o_info    = '{status: ST_TICK, load: 1'b0, rd_duty: 1'b0, adj: 1'b0,
                      add: 1'b0, steer: '0, clr: '0, sel: '0};
        if (i_tick) begin
            n_odd = !r_odd;
            if (!r_odd) begin
                o_info.load = 1'b1;
                if (idle_slot) begin
                    n_slot = '0;
                end else begin
                    o_info.rd_duty = 1'b1;
                    o_info.steer   = 4'b0001 << r_slot;
                    n_slot         = SLOT_W'(r_slot + 1'b1);
                end
            end else if (r_slot != '0) begin
                // clear the pin loaded on the previous even tick
                o_info.clr = 4'b0001 << SLOT_W'(r_slot - 1'b1);
            end
        end else begin
            case (i_key)
                KEY_1: begin
                    n_chosen      = 3'd0;
                    o_info.status = ST_SELECTED;
                end
                KEY_2: begin
                    n_chosen      = 3'd2;
                    o_info.status = ST_SELECTED;
                end
                KEY_3: begin
                    n_chosen      = 3'd1;
                    o_info.status = ST_SELECTED;
                end
                KEY_4: begin
                    n_chosen      = 3'd3;
                    o_info.status = ST_SELECTED;
                end
                KEY_ADD, KEY_SUB: begin
                    if (r_chosen == NO_SERVO) begin
                        o_info.status = ST_NO_SERVO;
                    end else begin
                        o_info.status = ST_ADJUSTED;
                        o_info.adj    = 1'b1;
                        o_info.add    = (i_key == KEY_ADD);
                    end
                end
                default: begin
                    o_info.status = ST_INVALID;
                end
            endcase
        end
        o_info.sel = n_chosen;
        addr_wide  = i_tick ? 4'(r_slot) : 4'(r_chosen);
        o_addr     = addr_wide[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chosen <= NO_SERVO;
            r_slot   <= '0;
            r_odd    <= 1'b0;
        end else if (i_accept) begin
            r_chosen <= n_chosen;
            r_slot   <= n_slot;
            r_odd    <= n_odd;
        end
    end

endmodule

[hw/rtl/four_channel_servo_pulse_sequencer.sv]
// Top level of the servo pulse sequencer: limits, update stage, result register.
//
// Channel   | Dir | Handshake                         | Beat contents
// ----------+-----+-----------------------------------+-------------------------------------
// s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready | tuser: operation; tdata: command_byte
// m_axis    | out | o_m_axis_tvalid / i_m_axis_tready | tdata: one result per input beat
// cfg       | in  | i_cfg_valid / o_cfg_ready         | i_cfg_index, i_cfg_data: width limit
//
// Throughput is one beat per cycle while m_axis does not stall. An accepted beat waits
// in the update stage for the registered read of the pulse width memory, then moves to
// the result register and leaves from there on m_axis.
// Reset is synchronous; per-entry valid bits restore the reset widths at once, so
// there is no clearing pass and the block takes beats from the first cycle.
// A stall on m_axis holds the result register and the update stage; s_axis keeps
// taking beats until both are full.
module four_channel_servo_pulse_sequencer #(
    parameter int unsigned NUM_CHANNELS = 4,   // 1..8
    parameter int unsigned STEP_SIZE    = 10   // 1..64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input beats
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [svseq_pkg::KEY_W-1:0]           i_s_axis_tdata,  // [7:0] command_byte
    input  logic [0:0]                            i_s_axis_tuser,  // [0] operation
    // result beats
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [2:0] status, [3] pwm_load, [13:4] pwm_duty, [17:14] steer_mask,
    // [21:18] clear_mask, [24:22] selected_channel, [31:25] zero
    output logic [svseq_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [svseq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [svseq_pkg::WIDTH_W-1:0]         i_cfg_data
);
    import svseq_pkg::*;

    // Keep at least four entries: servo keys reach channel 3 whatever the count.
    localparam int unsigned DEPTH  = (NUM_CHANNELS > 4) ? NUM_CHANNELS : 4;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned SUM_W  = WIDTH_W + 2;
    localparam int unsigned RES_W  = 3 + 1 + WIDTH_W + MASK_W + MASK_W + SEL_W;

    // Limits per channel, read by the selected channel in the update stage.
    logic [WIDTH_W-1:0] r_lim_hi [4];
    logic [WIDTH_W-1:0] r_lim_lo [4];

    logic               accept;
    logic               s1_go;
    t_s0_info           s0_info;
    logic [AW-1:0]      s0_addr;
    logic               r_s1_vld;
    t_s0_info           r_s1;
    logic [AW-1:0]      r_s1_addr;
    logic [WIDTH_W-1:0] rd_data;
    logic               wr_en;
    logic [WIDTH_W-1:0] n_width;
    logic [WIDTH_W-1:0] n_duty;
    logic [WIDTH_W-1:0] hi;
    logic [WIDTH_W-1:0] lo;
    logic signed [SUM_W-1:0] sum;
    logic [RES_W-1:0]   n_res;
    logic               r_out_vld;
    logic [RES_W-1:0]   r_out;

    assign s1_go           = r_s1_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_vld || s1_go;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Limit registers: even index is the max, odd index the min of a channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_hi <= MAX_RESET;
            r_lim_lo <= MIN_RESET;
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(REG_COUNT))) begin
            if (i_cfg_index[0]) begin
                r_lim_lo[i_cfg_index[2:1]] <= i_cfg_data;
            end else begin
                r_lim_hi[i_cfg_index[2:1]] <= i_cfg_data;
            end
        end
    end

    svseq_decode #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AW           (AW)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_tick   (i_s_axis_tuser[0]),
        .i_key    (i_s_axis_tdata),
        .o_info   (s0_info),
        .o_addr   (s0_addr)
    );

    svseq_width_mem #(
        .DEPTH (DEPTH)
    ) u_width_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (s0_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (n_width)
    );

    // Update stage: hold the decoded beat while the memory read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1      <= s0_info;
            r_s1_addr <= s0_addr;
        end
    end

    // Step the width, then clamp: first down to max, then up to min, so min
    // wins when the limits cross.
    always_comb begin
        hi  = r_lim_hi[r_s1_addr[1:0]];
        lo  = r_lim_lo[r_s1_addr[1:0]];
        sum = r_s1.add ? $signed({2'b00, rd_data}) + $signed(SUM_W'(STEP_SIZE))
                       : $signed({2'b00, rd_data}) - $signed(SUM_W'(STEP_SIZE));
        if (sum >= $signed({2'b00, hi})) begin
            sum = $signed({2'b00, hi});
        end
        if (sum <= $signed({2'b00, lo})) begin
            sum = $signed({2'b00, lo});
        end
        n_width = sum[WIDTH_W-1:0];
        n_duty  = r_s1.rd_duty ? rd_data : '0;
        n_res   = {r_s1.sel, r_s1.clr, r_s1.steer, n_duty, r_s1.load, r_s1.status};
    end

    assign wr_en = s1_go && r_s1.adj;

    // Result register: advance on s1_go, drop the beat once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out);

endmodule
